### rtl/rbm_pkg.sv
`timescale 1ns / 1ps

package rbm_pkg;

   localparam int COORD_WIDTH_DEF = 21;
   localparam int QUAT_FRAC_DEF   = 14;
   localparam int COORD_FRAC      = 10;
   localparam int OUT_W           = 24;
   localparam int QUAT_W          = 16;
   localparam int QPROD_W         = 2 * QUAT_W;
   localparam int MAT_W           = QPROD_W + 2;
   localparam int CSR_DATA_W      = 64;
   localparam int CSR_INDEX_W     = 3;
   localparam int VEC_REG_W       = 63;

   localparam logic [CSR_DATA_W-1:0] QUAT_RESET = 64'd16384;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_QUAT   = 3'd0,
      CSR_POS    = 3'd1,
      CSR_CENTER = 3'd2,
      CSR_LINVEL = 3'd3,
      CSR_ANGVEL = 3'd4,
      CSR_UPDATE = 3'd5
   } csr_index_type;

   // width of the rotated lever arm after rounding away the matrix fraction bits
   function automatic int arm_width(input int cw, input int qf);
      return cw + 1 + MAT_W + 2 - 2 * qf;
   endfunction

endpackage

### rtl/rbm_rotate.sv
`timescale 1ns / 1ps

module rbm_rotate #(
   parameter int CoordWidth   = rbm_pkg::COORD_WIDTH_DEF,
   parameter int QuatFracBits = rbm_pkg::QUAT_FRAC_DEF
) (
   input  logic                                                          clock,
   input  logic                                                          advance,
   input  logic [rbm_pkg::CSR_DATA_W-1:0]                                quat,
   input  logic signed [CoordWidth:0]                                    cp_x,
   input  logic signed [CoordWidth:0]                                    cp_y,
   input  logic signed [CoordWidth:0]                                    cp_z,
   output logic signed [rbm_pkg::arm_width(CoordWidth, QuatFracBits)-1:0] arm_x,
   output logic signed [rbm_pkg::arm_width(CoordWidth, QuatFracBits)-1:0] arm_y,
   output logic signed [rbm_pkg::arm_width(CoordWidth, QuatFracBits)-1:0] arm_z
);
   import rbm_pkg::*;

   localparam int CP_W  = CoordWidth + 1;
   localparam int MP_W  = MAT_W + CP_W;
   localparam int ACC_W = MP_W + 2;
   localparam int ARM_W = arm_width(CoordWidth, QuatFracBits);
   localparam int SHIFT = 2 * QuatFracBits;
   localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(1) << (SHIFT - 1);

   logic signed [QUAT_W-1:0]  q       [4];
   logic signed [QPROD_W-1:0] qp_in   [10];
   logic signed [QPROD_W-1:0] qp_ff   [10];
   logic signed [CP_W-1:0]    cp_in   [3];
   logic signed [CP_W-1:0]    s1_cp_ff[3];
   logic signed [CP_W-1:0]    s2_cp_ff[3];
   logic signed [MAT_W-1:0]   m_in    [9];
   logic signed [MAT_W-1:0]   m_ff    [9];
   logic signed [MP_W-1:0]    mp_in   [9];
   logic signed [MP_W-1:0]    mp_ff   [9];
   logic signed [ACC_W-1:0]   acc     [3];
   logic signed [ARM_W-1:0]   arm_in  [3];
   logic signed [ARM_W-1:0]   arm_ff  [3];

   function automatic logic signed [MAT_W-1:0] ext(input logic signed [QPROD_W-1:0] p);
      return MAT_W'(p);
   endfunction

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         q[k] = quat[k*QUAT_W +: QUAT_W];
      end
      qp_in[0] = q[0] * q[0];
      qp_in[1] = q[1] * q[1];
      qp_in[2] = q[2] * q[2];
      qp_in[3] = q[3] * q[3];
      qp_in[4] = q[1] * q[2];
      qp_in[5] = q[0] * q[3];
      qp_in[6] = q[0] * q[2];
      qp_in[7] = q[1] * q[3];
      qp_in[8] = q[2] * q[3];
      qp_in[9] = q[0] * q[1];
      cp_in[0] = cp_x;
      cp_in[1] = cp_y;
      cp_in[2] = cp_z;
   end

   always_comb begin
      m_in[0] = ext(qp_ff[0]) + ext(qp_ff[1]) - ext(qp_ff[2]) - ext(qp_ff[3]);
      m_in[1] = (ext(qp_ff[4]) - ext(qp_ff[5])) <<< 1;
      m_in[2] = (ext(qp_ff[6]) + ext(qp_ff[7])) <<< 1;
      m_in[3] = (ext(qp_ff[4]) + ext(qp_ff[5])) <<< 1;
      m_in[4] = ext(qp_ff[0]) - ext(qp_ff[1]) + ext(qp_ff[2]) - ext(qp_ff[3]);
      m_in[5] = (ext(qp_ff[8]) - ext(qp_ff[9])) <<< 1;
      m_in[6] = (ext(qp_ff[7]) - ext(qp_ff[6])) <<< 1;
      m_in[7] = (ext(qp_ff[9]) + ext(qp_ff[8])) <<< 1;
      m_in[8] = ext(qp_ff[0]) - ext(qp_ff[1]) - ext(qp_ff[2]) + ext(qp_ff[3]);
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            mp_in[r*3+c] = m_ff[r*3+c] * s2_cp_ff[c];
         end
      end
   end

   // round to nearest, ties up, then drop the matrix fraction bits
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         acc[r] = ACC_W'(mp_ff[r*3]) + ACC_W'(mp_ff[r*3+1]) + ACC_W'(mp_ff[r*3+2])
                + ACC_HALF;
         arm_in[r] = acc[r][SHIFT +: ARM_W];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < 10; k++) begin
            qp_ff[k] <= qp_in[k];
         end
         for (int k = 0; k < 9; k++) begin
            m_ff[k]  <= m_in[k];
            mp_ff[k] <= mp_in[k];
         end
         for (int k = 0; k < 3; k++) begin
            s1_cp_ff[k] <= cp_in[k];
            s2_cp_ff[k] <= s1_cp_ff[k];
            arm_ff[k]   <= arm_in[k];
         end
      end
   end

   assign arm_x = arm_ff[0];
   assign arm_y = arm_ff[1];
   assign arm_z = arm_ff[2];

endmodule

### rtl/rigid_body_node_motion.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_stall  req_ref_x, req_ref_y, req_ref_z
// rsp_      out        rsp_valid / rsp_stall  disp, node_vel, moved (x, y, z), moved_valid
// csr_      in         csr_write              csr_index, csr_wdata
//
// Six register stages: quaternion products, matrix, matrix times lever arm,
// rounded arm, cross products and moved point, saturated result register.
// One transaction per cycle unless a stalled result holds the pipeline.
// Synchronous reset clears the stage valid bits and loads the register defaults.
// A stalled result holds the whole pipeline; req_stall follows rsp_stall then.

module rigid_body_node_motion #(
   parameter int CoordWidth   = rbm_pkg::COORD_WIDTH_DEF,
   parameter int QuatFracBits = rbm_pkg::QUAT_FRAC_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic signed [CoordWidth-1:0]            req_ref_x,
   input  logic signed [CoordWidth-1:0]            req_ref_y,
   input  logic signed [CoordWidth-1:0]            req_ref_z,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [rbm_pkg::OUT_W-1:0]        rsp_disp_x,
   output logic signed [rbm_pkg::OUT_W-1:0]        rsp_disp_y,
   output logic signed [rbm_pkg::OUT_W-1:0]        rsp_disp_z,
   output logic signed [rbm_pkg::OUT_W-1:0]        rsp_node_vel_x,
   output logic signed [rbm_pkg::OUT_W-1:0]        rsp_node_vel_y,
   output logic signed [rbm_pkg::OUT_W-1:0]        rsp_node_vel_z,
   output logic signed [rbm_pkg::OUT_W-1:0]        rsp_moved_x,
   output logic signed [rbm_pkg::OUT_W-1:0]        rsp_moved_y,
   output logic signed [rbm_pkg::OUT_W-1:0]        rsp_moved_z,
   output logic                                    rsp_moved_valid,
   input  logic                                    csr_write,
   input  logic [rbm_pkg::CSR_INDEX_W-1:0]         csr_index,
   input  logic [rbm_pkg::CSR_DATA_W-1:0]          csr_wdata
);
   import rbm_pkg::*;

   localparam int CP_W     = CoordWidth + 1;
   localparam int ARM_W    = arm_width(CoordWidth, QuatFracBits);
   localparam int NP_W     = ARM_W + 1;
   localparam int DISP_W   = ARM_W + 2;
   localparam int XP_W     = CoordWidth + ARM_W;
   localparam int DIFF_W   = XP_W + 2;
   localparam int VEL_W    = DIFF_W - COORD_FRAC;
   localparam int STAGES   = 6;
   localparam int REF_DLY  = 4;
   localparam logic signed [DIFF_W-1:0] VEL_HALF = DIFF_W'(1) << (COORD_FRAC - 1);

   logic [CSR_DATA_W-1:0] quat_ff;
   logic [VEC_REG_W-1:0]  pos_ff;
   logic [VEC_REG_W-1:0]  center_ff;
   logic [VEC_REG_W-1:0]  linvel_ff;
   logic [VEC_REG_W-1:0]  angvel_ff;
   logic                  update_ff;
   csr_index_type         csr_sel;

   logic                  advance;
   logic                  valid_in [STAGES];
   logic                  valid_ff [STAGES];

   logic signed [CoordWidth-1:0] ref_in  [3];
   logic signed [CoordWidth-1:0] ref_ff  [REF_DLY][3];
   logic signed [CoordWidth-1:0] center  [3];
   logic signed [CoordWidth-1:0] pos     [3];
   logic signed [CoordWidth-1:0] angvel  [3];
   logic signed [CoordWidth-1:0] linvel  [3];
   logic signed [CP_W-1:0]       cp      [3];
   logic signed [ARM_W-1:0]      arm     [3];

   logic signed [NP_W-1:0]       np_in   [3];
   logic signed [NP_W-1:0]       np_ff   [3];
   logic signed [DISP_W-1:0]     disp_in [3];
   logic signed [DISP_W-1:0]     disp_ff [3];
   logic signed [XP_W-1:0]       xp_in   [6];
   logic signed [XP_W-1:0]       xp_ff   [6];

   logic signed [DIFF_W-1:0]     diff    [3];
   logic signed [VEL_W-1:0]      vel     [3];
   logic signed [OUT_W-1:0]      disp_out_in  [3];
   logic signed [OUT_W-1:0]      disp_out_ff  [3];
   logic signed [OUT_W-1:0]      vel_out_in   [3];
   logic signed [OUT_W-1:0]      vel_out_ff   [3];
   logic signed [OUT_W-1:0]      moved_out_in [3];
   logic signed [OUT_W-1:0]      moved_out_ff [3];
   logic                         moved_valid_ff;

   function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [VEL_W-1:0] v);
      logic [VEL_W-OUT_W:0] upper;
      upper = v[VEL_W-1:OUT_W-1];
      if ((&upper) || !(|upper)) begin
         return v[OUT_W-1:0];
      end
      return v[VEL_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
   endfunction

   assign csr_sel = csr_index_type'(csr_index);

   always_ff @(posedge clock) begin
      if (reset) begin
         quat_ff   <= QUAT_RESET;
         pos_ff    <= '0;
         center_ff <= '0;
         linvel_ff <= '0;
         angvel_ff <= '0;
         update_ff <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_sel)
            CSR_QUAT: begin
               quat_ff <= csr_wdata;
            end
            CSR_POS: begin
               pos_ff <= csr_wdata[VEC_REG_W-1:0];
            end
            CSR_CENTER: begin
               center_ff <= csr_wdata[VEC_REG_W-1:0];
            end
            CSR_LINVEL: begin
               linvel_ff <= csr_wdata[VEC_REG_W-1:0];
            end
            CSR_ANGVEL: begin
               angvel_ff <= csr_wdata[VEC_REG_W-1:0];
            end
            CSR_UPDATE: begin
               update_ff <= csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   // hold every stage while a finished transaction waits at the output
   assign advance   = !(valid_ff[STAGES-1] && rsp_stall);
   assign req_stall = !advance;

   always_comb begin
      valid_in[0] = req_valid;
      for (int s = 1; s < STAGES; s++) begin
         valid_in[s] = valid_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < STAGES; s++) begin
            valid_ff[s] <= 1'b0;
         end
      end else if (advance) begin
         for (int s = 0; s < STAGES; s++) begin
            valid_ff[s] <= valid_in[s];
         end
      end
   end

   always_comb begin
      ref_in[0] = req_ref_x;
      ref_in[1] = req_ref_y;
      ref_in[2] = req_ref_z;
      for (int k = 0; k < 3; k++) begin
         center[k] = center_ff[k*CoordWidth +: CoordWidth];
         pos[k]    = pos_ff[k*CoordWidth +: CoordWidth];
         angvel[k] = angvel_ff[k*CoordWidth +: CoordWidth];
         linvel[k] = linvel_ff[k*CoordWidth +: CoordWidth];
         cp[k]     = CP_W'(ref_in[k]) - CP_W'(center[k]);
      end
   end

   rbm_rotate #(
      .CoordWidth  (CoordWidth),
      .QuatFracBits(QuatFracBits)
   ) u_rotate (
      .clock  (clock),
      .advance(advance),
      .quat   (quat_ff),
      .cp_x   (cp[0]),
      .cp_y   (cp[1]),
      .cp_z   (cp[2]),
      .arm_x  (arm[0]),
      .arm_y  (arm[1]),
      .arm_z  (arm[2])
   );

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         np_in[k]   = NP_W'(arm[k]) + NP_W'(pos[k]);
         disp_in[k] = DISP_W'(arm[k]) + DISP_W'(pos[k]) - DISP_W'(ref_ff[REF_DLY-1][k]);
      end
      xp_in[0] = angvel[1] * arm[2];
      xp_in[1] = angvel[2] * arm[1];
      xp_in[2] = angvel[2] * arm[0];
      xp_in[3] = angvel[0] * arm[2];
      xp_in[4] = angvel[0] * arm[1];
      xp_in[5] = angvel[1] * arm[0];
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         diff[k] = DIFF_W'(xp_ff[2*k]) - DIFF_W'(xp_ff[2*k+1]) + VEL_HALF;
         vel[k]  = diff[k][COORD_FRAC +: VEL_W] + VEL_W'(linvel[k]);
         disp_out_in[k]  = sat_out(VEL_W'(disp_ff[k]));
         vel_out_in[k]   = sat_out(vel[k]);
         moved_out_in[k] = update_ff ? sat_out(VEL_W'(np_ff[k])) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < 3; k++) begin
            ref_ff[0][k] <= ref_in[k];
            for (int d = 1; d < REF_DLY; d++) begin
               ref_ff[d][k] <= ref_ff[d-1][k];
            end
            np_ff[k]        <= np_in[k];
            disp_ff[k]      <= disp_in[k];
            disp_out_ff[k]  <= disp_out_in[k];
            vel_out_ff[k]   <= vel_out_in[k];
            moved_out_ff[k] <= moved_out_in[k];
         end
         for (int k = 0; k < 6; k++) begin
            xp_ff[k] <= xp_in[k];
         end
         moved_valid_ff <= update_ff;
      end
   end

   assign rsp_valid       = valid_ff[STAGES-1];
   assign rsp_disp_x      = disp_out_ff[0];
   assign rsp_disp_y      = disp_out_ff[1];
   assign rsp_disp_z      = disp_out_ff[2];
   assign rsp_node_vel_x  = vel_out_ff[0];
   assign rsp_node_vel_y  = vel_out_ff[1];
   assign rsp_node_vel_z  = vel_out_ff[2];
   assign rsp_moved_x     = moved_out_ff[0];
   assign rsp_moved_y     = moved_out_ff[1];
   assign rsp_moved_z     = moved_out_ff[2];
   assign rsp_moved_valid = moved_valid_ff;

endmodule

### verif/rbm_checker.sv
`timescale 1ns / 1ps

module rbm_checker (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   input  logic                                     req_stall,
   input  logic signed [rbm_pkg::COORD_WIDTH_DEF-1:0] req_ref_x,
   input  logic signed [rbm_pkg::COORD_WIDTH_DEF-1:0] req_ref_y,
   input  logic signed [rbm_pkg::COORD_WIDTH_DEF-1:0] req_ref_z,
   input  logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   input  logic signed [rbm_pkg::OUT_W-1:0]         rsp_disp_x,
   input  logic signed [rbm_pkg::OUT_W-1:0]         rsp_disp_y,
   input  logic signed [rbm_pkg::OUT_W-1:0]         rsp_disp_z,
   input  logic signed [rbm_pkg::OUT_W-1:0]         rsp_node_vel_x,
   input  logic signed [rbm_pkg::OUT_W-1:0]         rsp_node_vel_y,
   input  logic signed [rbm_pkg::OUT_W-1:0]         rsp_node_vel_z,
   input  logic signed [rbm_pkg::OUT_W-1:0]         rsp_moved_x,
   input  logic signed [rbm_pkg::OUT_W-1:0]         rsp_moved_y,
   input  logic signed [rbm_pkg::OUT_W-1:0]         rsp_moved_z,
   input  logic                                     rsp_moved_valid,
   input  logic                                     csr_write,
   input  logic [rbm_pkg::CSR_INDEX_W-1:0]          csr_index,
   input  logic [rbm_pkg::CSR_DATA_W-1:0]           csr_wdata,
   output int                                       fail_count,
   output int                                       outstanding,
   output int                                       results_seen
);

   localparam int CW    = rbm_pkg::COORD_WIDTH_DEF;
   localparam int OW    = rbm_pkg::OUT_W;
   localparam int VW    = rbm_pkg::VEC_REG_W;
   localparam int QW    = rbm_pkg::QUAT_W;
   localparam int ARM_SHIFT = 2 * rbm_pkg::QUAT_FRAC_DEF;
   localparam longint OUT_MAX = (longint'(1) << (OW - 1)) - 1;
   localparam longint OUT_MIN = -OUT_MAX - 1;

   typedef struct packed {
      logic signed [OW-1:0] disp_x;
      logic signed [OW-1:0] disp_y;
      logic signed [OW-1:0] disp_z;
      logic signed [OW-1:0] vel_x;
      logic signed [OW-1:0] vel_y;
      logic signed [OW-1:0] vel_z;
      logic signed [OW-1:0] moved_x;
      logic signed [OW-1:0] moved_y;
      logic signed [OW-1:0] moved_z;
      logic                 moved_valid;
   } node_motion_type;

   logic [rbm_pkg::CSR_DATA_W-1:0] quat_reg;
   logic [VW-1:0]                  position_reg;
   logic [VW-1:0]                  center_reg;
   logic [VW-1:0]                  linvel_reg;
   logic [VW-1:0]                  angvel_reg;
   logic                           update_reg;

   node_motion_type expected_motion[$];

   function automatic longint quat_part(input int k);
      logic signed [QW-1:0] p;
      p = quat_reg[k*QW +: QW];
      return p;
   endfunction

   function automatic longint coord_part(input logic [VW-1:0] vec, input int k);
      logic signed [CW-1:0] c;
      c = vec[k*CW +: CW];
      return c;
   endfunction

   // round to nearest, ties toward plus infinity
   function automatic longint round_nearest(input longint v, input int s);
      longint t;
      t = v + (longint'(1) << (s - 1));
      return t >>> s;
   endfunction

   function automatic logic signed [OW-1:0] clamp_out(input longint v);
      longint c;
      c = v;
      if (c > OUT_MAX) c = OUT_MAX;
      if (c < OUT_MIN) c = OUT_MIN;
      return c[OW-1:0];
   endfunction

   function automatic node_motion_type predict_motion(input logic signed [CW-1:0] rx,
                                                      input logic signed [CW-1:0] ry,
                                                      input logic signed [CW-1:0] rz);
      longint q0, q1, q2, q3;
      longint rot [9];
      longint refp [3];
      longint lever [3];
      longint arm [3];
      longint moved [3];
      longint w [3];
      longint vel [3];
      node_motion_type r;
      int i;
      q0 = quat_part(0);
      q1 = quat_part(1);
      q2 = quat_part(2);
      q3 = quat_part(3);
      rot[0] = q0 * q0 + q1 * q1 - q2 * q2 - q3 * q3;
      rot[1] = 2 * (q1 * q2 - q0 * q3);
      rot[2] = 2 * (q0 * q2 + q1 * q3);
      rot[3] = 2 * (q1 * q2 + q0 * q3);
      rot[4] = q0 * q0 - q1 * q1 + q2 * q2 - q3 * q3;
      rot[5] = 2 * (q2 * q3 - q0 * q1);
      rot[6] = 2 * (q1 * q3 - q0 * q2);
      rot[7] = 2 * (q0 * q1 + q2 * q3);
      rot[8] = q0 * q0 - q1 * q1 - q2 * q2 + q3 * q3;
      refp[0] = rx;
      refp[1] = ry;
      refp[2] = rz;
      for (i = 0; i < 3; i++) begin
         lever[i] = refp[i] - coord_part(center_reg, i);
         w[i]     = coord_part(angvel_reg, i);
      end
      for (i = 0; i < 3; i++) begin
         arm[i] = round_nearest(rot[3*i] * lever[0] + rot[3*i+1] * lever[1]
                                + rot[3*i+2] * lever[2], ARM_SHIFT);
         moved[i] = arm[i] + coord_part(position_reg, i);
      end
      vel[0] = round_nearest(w[1] * arm[2] - w[2] * arm[1], rbm_pkg::COORD_FRAC);
      vel[1] = round_nearest(w[2] * arm[0] - w[0] * arm[2], rbm_pkg::COORD_FRAC);
      vel[2] = round_nearest(w[0] * arm[1] - w[1] * arm[0], rbm_pkg::COORD_FRAC);
      r.disp_x  = clamp_out(moved[0] - refp[0]);
      r.disp_y  = clamp_out(moved[1] - refp[1]);
      r.disp_z  = clamp_out(moved[2] - refp[2]);
      r.vel_x   = clamp_out(vel[0] + coord_part(linvel_reg, 0));
      r.vel_y   = clamp_out(vel[1] + coord_part(linvel_reg, 1));
      r.vel_z   = clamp_out(vel[2] + coord_part(linvel_reg, 2));
      r.moved_x = update_reg ? clamp_out(moved[0]) : '0;
      r.moved_y = update_reg ? clamp_out(moved[1]) : '0;
      r.moved_z = update_reg ? clamp_out(moved[2]) : '0;
      r.moved_valid = update_reg;
      return r;
   endfunction

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         fail_count++;
         $error("%s: expected %0d, got %0d", name, want, got);
      end
   endtask

   always @(posedge clock) begin
      node_motion_type want;
      if (reset) begin
         quat_reg     = rbm_pkg::QUAT_RESET;
         position_reg = '0;
         center_reg   = '0;
         linvel_reg   = '0;
         angvel_reg   = '0;
         update_reg   = 1'b0;
         expected_motion.delete();
         results_seen = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (expected_motion.size() == 0) begin
               fail_count++;
               $error("result transaction with no expectation pending");
            end else begin
               want = expected_motion.pop_front();
               check_field("disp_x", want.disp_x, rsp_disp_x);
               check_field("disp_y", want.disp_y, rsp_disp_y);
               check_field("disp_z", want.disp_z, rsp_disp_z);
               check_field("node_vel_x", want.vel_x, rsp_node_vel_x);
               check_field("node_vel_y", want.vel_y, rsp_node_vel_y);
               check_field("node_vel_z", want.vel_z, rsp_node_vel_z);
               check_field("moved_x", want.moved_x, rsp_moved_x);
               check_field("moved_y", want.moved_y, rsp_moved_y);
               check_field("moved_z", want.moved_z, rsp_moved_z);
               check_field("moved_valid", want.moved_valid, rsp_moved_valid);
            end
         end
         if (req_valid && !req_stall) begin
            expected_motion.push_back(predict_motion(req_ref_x, req_ref_y, req_ref_z));
         end
         if (csr_write) begin
            case (csr_index)
               rbm_pkg::CSR_QUAT:   quat_reg     = csr_wdata;
               rbm_pkg::CSR_POS:    position_reg = csr_wdata[VW-1:0];
               rbm_pkg::CSR_CENTER: center_reg   = csr_wdata[VW-1:0];
               rbm_pkg::CSR_LINVEL: linvel_reg   = csr_wdata[VW-1:0];
               rbm_pkg::CSR_ANGVEL: angvel_reg   = csr_wdata[VW-1:0];
               rbm_pkg::CSR_UPDATE: update_reg   = csr_wdata[0];
               default: ;
            endcase
         end
      end
      outstanding = expected_motion.size();
   end

endmodule

### verif/tb.sv
`timescale 1ns / 1ps

module tb;

   localparam int CW           = rbm_pkg::COORD_WIDTH_DEF;
   localparam int OW           = rbm_pkg::OUT_W;
   localparam int VW           = rbm_pkg::VEC_REG_W;
   localparam int QW           = rbm_pkg::QUAT_W;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int DRAIN_CYCLES = 10;
   localparam int LONG_HOLD    = 150;
   localparam int SEGMENTS     = 6;
   localparam int SEGMENT_ITEMS = 95;
   localparam int BURST_ITEMS  = 40;

   localparam logic [rbm_pkg::CSR_INDEX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [rbm_pkg::CSR_INDEX_W-1:0] CSR_SPARE_HI = 3'd7;

   localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
   localparam logic signed [CW-1:0] CNEG1 = '1;
   localparam logic signed [CW-1:0] CZERO = '0;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic signed [CW-1:0] req_ref_x;
   logic signed [CW-1:0] req_ref_y;
   logic signed [CW-1:0] req_ref_z;
   logic rsp_valid;
   logic rsp_stall;
   logic signed [OW-1:0] rsp_disp_x;
   logic signed [OW-1:0] rsp_disp_y;
   logic signed [OW-1:0] rsp_disp_z;
   logic signed [OW-1:0] rsp_node_vel_x;
   logic signed [OW-1:0] rsp_node_vel_y;
   logic signed [OW-1:0] rsp_node_vel_z;
   logic signed [OW-1:0] rsp_moved_x;
   logic signed [OW-1:0] rsp_moved_y;
   logic signed [OW-1:0] rsp_moved_z;
   logic rsp_moved_valid;
   logic csr_write;
   logic [rbm_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [rbm_pkg::CSR_DATA_W-1:0]  csr_wdata;

   int fail_count;
   int outstanding;
   int results_seen;

   int send_idle_pct;
   int recv_idle_pct;
   int hold_requests;
   int holds_served;
   int hold_left;
   int node_count;
   int pose_count;
   int cycle_count;
   logic [VW-1:0] center_now;

   int send_pcts [3] = '{24, 67, 0};
   int recv_pcts [3] = '{67, 24, 0};

   always #10 clock = ~clock;

   rigid_body_node_motion dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_ref_x       (req_ref_x),
      .req_ref_y       (req_ref_y),
      .req_ref_z       (req_ref_z),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_disp_x      (rsp_disp_x),
      .rsp_disp_y      (rsp_disp_y),
      .rsp_disp_z      (rsp_disp_z),
      .rsp_node_vel_x  (rsp_node_vel_x),
      .rsp_node_vel_y  (rsp_node_vel_y),
      .rsp_node_vel_z  (rsp_node_vel_z),
      .rsp_moved_x     (rsp_moved_x),
      .rsp_moved_y     (rsp_moved_y),
      .rsp_moved_z     (rsp_moved_z),
      .rsp_moved_valid (rsp_moved_valid),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   rbm_checker checker_i (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_ref_x       (req_ref_x),
      .req_ref_y       (req_ref_y),
      .req_ref_z       (req_ref_z),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_disp_x      (rsp_disp_x),
      .rsp_disp_y      (rsp_disp_y),
      .rsp_disp_z      (rsp_disp_z),
      .rsp_node_vel_x  (rsp_node_vel_x),
      .rsp_node_vel_y  (rsp_node_vel_y),
      .rsp_node_vel_z  (rsp_node_vel_z),
      .rsp_moved_x     (rsp_moved_x),
      .rsp_moved_y     (rsp_moved_y),
      .rsp_moved_z     (rsp_moved_z),
      .rsp_moved_valid (rsp_moved_valid),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .outstanding     (outstanding),
      .results_seen    (results_seen)
   );

   // result side: random stalls, plus a long hold-off on request
   initial begin
      rsp_stall    = 1'b0;
      holds_served = 0;
      hold_left    = 0;
      forever begin
         @(negedge clock);
         if (hold_requests != holds_served) begin
            holds_served++;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb failed");
      $finish;
   end

   function automatic logic [VW-1:0] pack3(input logic signed [CW-1:0] x,
                                          input logic signed [CW-1:0] y,
                                          input logic signed [CW-1:0] z);
      return {z, y, x};
   endfunction

   function automatic logic [rbm_pkg::CSR_DATA_W-1:0] pack4(input logic [QW-1:0] q0,
                                                           input logic [QW-1:0] q1,
                                                           input logic [QW-1:0] q2,
                                                           input logic [QW-1:0] q3);
      return {q3, q2, q1, q0};
   endfunction

   function automatic logic signed [CW-1:0] rand_coord(input int span);
      logic [31:0] bits;
      int offset;
      bits = $urandom;
      if (span >= CW - 1) return bits[CW-1:0];
      offset = int'($urandom_range((1 << (span + 1)) - 1)) - (1 << span);
      return offset[CW-1:0];
   endfunction

   function automatic logic [VW-1:0] rand_vec(input int span);
      return pack3(rand_coord(span), rand_coord(span), rand_coord(span));
   endfunction

   function automatic logic signed [CW-1:0] extreme_coord();
      case ($urandom_range(3))
         0: return CMAX;
         1: return CMIN;
         2: return CZERO;
         default: return CNEG1;
      endcase
   endfunction

   // random unit quaternion, scaled to the part format
   function automatic logic [rbm_pkg::CSR_DATA_W-1:0] unit_quat();
      real part [4];
      real norm;
      logic [rbm_pkg::CSR_DATA_W-1:0] quat_bits;
      longint v;
      int k;
      norm = 0.0;
      for (k = 0; k < 4; k++) begin
         part[k] = real'(int'($urandom_range(2000)) - 1000);
         norm = norm + part[k] * part[k];
      end
      if (norm < 1.0) return rbm_pkg::QUAT_RESET;
      norm = $sqrt(norm);
      for (k = 0; k < 4; k++) begin
         v = longint'(part[k] / norm * real'(1 << rbm_pkg::QUAT_FRAC_DEF));
         quat_bits[k*QW +: QW] = v[QW-1:0];
      end
      return quat_bits;
   endfunction

   task automatic write_reg(input logic [rbm_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [rbm_pkg::CSR_DATA_W-1:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
   endtask

   task automatic apply_pose(input logic [rbm_pkg::CSR_DATA_W-1:0] quat,
                             input logic [rbm_pkg::CSR_DATA_W-1:0] position,
                             input logic [rbm_pkg::CSR_DATA_W-1:0] center,
                             input logic [rbm_pkg::CSR_DATA_W-1:0] linvel,
                             input logic [rbm_pkg::CSR_DATA_W-1:0] angvel,
                             input logic [rbm_pkg::CSR_DATA_W-1:0] update);
      write_reg(rbm_pkg::CSR_QUAT, quat);
      write_reg(rbm_pkg::CSR_POS, position);
      write_reg(rbm_pkg::CSR_CENTER, center);
      write_reg(rbm_pkg::CSR_LINVEL, linvel);
      write_reg(rbm_pkg::CSR_ANGVEL, angvel);
      write_reg(rbm_pkg::CSR_UPDATE, update);
      // unmapped index must be ignored
      write_reg($urandom_range(1) ? CSR_SPARE_HI : CSR_SPARE_LO, {$urandom, $urandom});
      csr_write  <= 1'b0;
      center_now = center[VW-1:0];
      pose_count++;
   endtask

   task automatic offer_node(input logic signed [CW-1:0] x,
                             input logic signed [CW-1:0] y,
                             input logic signed [CW-1:0] z);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_ref_x <= x;
      req_ref_y <= y;
      req_ref_z <= z;
      do @(posedge clock); while (req_stall);
      node_count++;
      @(negedge clock);
   endtask

   task automatic offer_random_node();
      logic signed [CW-1:0] c [3];
      logic signed [CW-1:0] base;
      int pick;
      int k;
      pick = $urandom_range(99);
      for (k = 0; k < 3; k++) begin
         base = center_now[k*CW +: CW];
         if (pick < 15) c[k] = rand_coord(CW);
         else if (pick < 22) c[k] = extreme_coord();
         else c[k] = base + rand_coord(12);
      end
      offer_node(c[0], c[1], c[2]);
   endtask

   // drop valid and wait until every pending transaction has come back
   task automatic settle();
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic random_segment(input int count);
      logic [rbm_pkg::CSR_DATA_W-1:0] quat;
      int i;
      settle();
      if ($urandom_range(99) < 70) quat = unit_quat();
      else quat = {$urandom, $urandom};
      apply_pose(quat, rand_vec($urandom_range(8, CW)), rand_vec($urandom_range(8, CW)),
                 rand_vec($urandom_range(6, CW)), rand_vec($urandom_range(4, 14)),
                 $urandom_range(1));
      for (i = 0; i < count; i++) offer_random_node();
   endtask

   initial begin
      int mode;
      int seg;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_ref_x     = '0;
      req_ref_y     = '0;
      req_ref_z     = '0;
      csr_write     = 1'b0;
      csr_index     = '0;
      csr_wdata     = '0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_requests = 0;
      node_count    = 0;
      pose_count    = 0;
      center_now    = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset pose: identity rotation, moved point not flagged
      offer_node(CZERO, CZERO, CZERO);
      offer_node(CMAX, CMAX, CMAX);
      offer_node(CMIN, CMIN, CMIN);
      offer_node(CMAX, CMIN, CNEG1);

      // most negative parts everywhere: heavy scaling, saturation
      settle();
      apply_pose({4{16'h8000}}, pack3(CMAX, CMAX, CMAX), pack3(CMIN, CMIN, CMIN),
                 pack3(CMAX, CMAX, CMAX), pack3(CMAX, CMAX, CMAX), 64'd1);
      offer_node(CMAX, CMAX, CMAX);
      offer_node(CMIN, CMIN, CMIN);
      offer_node(CZERO, CZERO, CZERO);
      offer_node(21'sd1, CNEG1, 21'sd1);

      // most positive parts, oversized register values
      settle();
      apply_pose({4{16'h7FFF}}, {1'b1, pack3(CMIN, CMIN, CMIN)},
                 {1'b1, pack3(CMAX, CMAX, CMAX)}, {1'b1, pack3(CMIN, CMIN, CMIN)},
                 {1'b1, pack3(CMIN, CMIN, CMIN)}, 64'hFFFF_FFFF_FFFF_FFFF);
      offer_node(CMAX, CMAX, CMAX);
      offer_node(CMIN, CMIN, CMIN);
      offer_node(CMAX, CZERO, CMIN);
      offer_node(CNEG1, CNEG1, CNEG1);

      // quarter turn about z, update cleared by an oversized value
      settle();
      apply_pose(pack4(16'd11585, 16'd0, 16'd0, 16'd11585), pack3(21'sd1024, -21'sd2048, 21'sd512),
                 pack3(-21'sd512, CZERO, 21'sd256), pack3(21'sd100, -21'sd100, CZERO),
                 pack3(21'sd1024, -21'sd1024, 21'sd2048), 64'hFFFF_FFFF_FFFF_FFFE);
      offer_node(21'sd1, 21'sd1, 21'sd1);
      offer_node(CNEG1, CNEG1, CNEG1);
      offer_node(CMAX, CZERO, CMIN);
      offer_node(21'sd512, -21'sd512, 21'sd1);

      for (mode = 0; mode < 3; mode++) begin
         send_idle_pct = send_pcts[mode];
         recv_idle_pct = recv_pcts[mode];
         for (seg = 0; seg < SEGMENTS; seg++) begin
            if (mode == 2 && seg == 3) begin
               // hold results off while items keep coming
               settle();
               hold_requests++;
               repeat (BURST_ITEMS) offer_random_node();
            end
            random_segment(SEGMENT_ITEMS);
         end
      end

      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("Run covered %0d node transactions and %0d checked results over %0d poses,",
               node_count, results_seen, pose_count);
      $display("with extreme, non-unit and unit rotations, three idle mixes and a long hold-off.");
      if (fail_count == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule
